### rtl/core/wssc_pkg.sv
// ----------------------------------------------------------------------------
// wssc_pkg: shared types and constants of the weighted sample slot cache
// Slot geometry, weight limits, action and command codes, and the packets
// that travel along the slot chain.
// ----------------------------------------------------------------------------
package wssc_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int KEY_W  = 16;
  localparam int PRIO_W = 8;
  localparam int WGT_W  = 16;
  localparam int TICK_W = 8;
  localparam int IDX_W  = 4;   // width of the slot_index result field

  localparam logic signed [WGT_W-1:0] WEIGHT_CEIL = 16'sd32000;
  localparam logic signed [WGT_W-1:0] WEIGHT_MAX  = 16'sh7fff;
  localparam logic signed [WGT_W-1:0] WEIGHT_MIN  = 16'sh8000;
  localparam logic [TICK_W-1:0]       DECAY_RESET = 8'd60;
  localparam int                      MISS_GAIN   = 5;

  // APB register map
  localparam int                 PADDR_W      = 3;
  localparam logic [PADDR_W-1:0] ADDR_DECAY   = 3'd0;

  typedef enum logic [1:0] {
    ACT_RESERVE = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_HIT   = 3'd1,
    OP_FILL  = 3'd2,
    OP_DECAY = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  // Search packet handed from cell to cell.
  typedef struct packed {
    logic                     hit;
    logic [SLOT_W-1:0]        hit_idx;
    logic                     free;
    logic [SLOT_W-1:0]        free_idx;
    logic                     best;
    logic [SLOT_W-1:0]        best_idx;
    logic signed [WGT_W-1:0]  best_wgt;
  } scan_t;

  // Update broadcast to all cells; acted on for one cycle.
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic             hit;
    logic             evicted;
    logic             fault;
  } res_t;

  localparam scan_t SCAN_INIT = '{
    hit: 1'b0, hit_idx: '0, free: 1'b0, free_idx: '0,
    best: 1'b0, best_idx: '0, best_wgt: WEIGHT_CEIL
  };

endpackage

### rtl/core/wssc_if.sv
// ----------------------------------------------------------------------------
// wssc_if: request and response channels of the slot cache
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface wssc_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [wssc_pkg::KEY_W-1:0]    sound_key;
  logic [wssc_pkg::PRIO_W-1:0]   priority_req;

  modport source (output valid, action, sound_key, priority_req, input ready);
  modport sink   (input valid, action, sound_key, priority_req, output ready);
endinterface

interface wssc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [wssc_pkg::IDX_W-1:0]    slot_index;
  logic                          hit;
  logic                          evicted;
  logic                          fault;

  modport source (output valid, slot_index, hit, evicted, fault, input ready);
  modport sink   (input valid, slot_index, hit, evicted, fault, output ready);
endinterface

### rtl/core/wssc_cfg.sv
// ----------------------------------------------------------------------------
// wssc_cfg: APB register file
// Holds the decay period; writes complete in the access phase.
// ----------------------------------------------------------------------------
module wssc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wssc_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [wssc_pkg::TICK_W-1:0]      decay_period_o
);

  logic [wssc_pkg::TICK_W-1:0] decay_q, decay_d;
  logic                        sel_decay;

  // register index is paddr / 4; byte lanes ignored
  assign sel_decay = (paddr[wssc_pkg::PADDR_W-1:2] == wssc_pkg::ADDR_DECAY[wssc_pkg::PADDR_W-1:2]);

  always_comb begin
    decay_d = decay_q;
    if (psel && penable && pwrite && sel_decay) begin
      decay_d = pwdata[wssc_pkg::TICK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= wssc_pkg::DECAY_RESET;
    end else begin
      decay_q <= decay_d;
    end
  end

  assign pready         = 1'b1;
  assign prdata         = sel_decay ? {{(32-wssc_pkg::TICK_W){1'b0}}, decay_q} : 32'd0;
  assign decay_period_o = decay_q;

endmodule

### rtl/core/wssc_cell.sv
// ----------------------------------------------------------------------------
// wssc_cell: one cache slot
// Holds key, valid and weight; folds itself into the passing search packet
// and applies broadcast updates addressed to it.
// ----------------------------------------------------------------------------
module wssc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [wssc_pkg::SLOT_W-1:0]    cell_idx_i,
  input  logic [wssc_pkg::KEY_W-1:0]     key_i,
  input  logic [wssc_pkg::PRIO_W-1:0]    prio_i,
  input  wssc_pkg::cmd_t                 cmd_i,
  input  wssc_pkg::scan_t                scan_i,
  output wssc_pkg::scan_t                scan_o
);

  localparam int SUM_W = wssc_pkg::WGT_W + 2;

  logic                                 valid_q, valid_d;
  logic signed [wssc_pkg::WGT_W-1:0]    wgt_q, wgt_d;
  logic [wssc_pkg::KEY_W-1:0]           key_q, key_d;
  wssc_pkg::scan_t                      scan_q, scan_d;
  logic signed [SUM_W-1:0]              hit_sum;
  logic [wssc_pkg::WGT_W-1:0]           fill_wgt;
  logic                                 me;

  assign me       = (cmd_i.idx == cell_idx_i);
  assign hit_sum  = SUM_W'(wgt_q) + $signed({2'b00, {(wssc_pkg::WGT_W-wssc_pkg::PRIO_W){1'b0}},
                                              prio_i}) + SUM_W'(1);
  assign fill_wgt = wssc_pkg::WGT_W'(prio_i) * wssc_pkg::WGT_W'(wssc_pkg::MISS_GAIN);

  // search: first hit, first free slot, lowest weight below the ceiling
  always_comb begin
    scan_d = scan_i;
    if (!scan_i.hit && valid_q && (key_q == key_i)) begin
      scan_d.hit     = 1'b1;
      scan_d.hit_idx = cell_idx_i;
    end
    if (!scan_i.free && !valid_q) begin
      scan_d.free     = 1'b1;
      scan_d.free_idx = cell_idx_i;
    end
    if (valid_q && (wgt_q < scan_i.best_wgt)) begin
      scan_d.best     = 1'b1;
      scan_d.best_idx = cell_idx_i;
      scan_d.best_wgt = wgt_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    wgt_d   = wgt_q;
    key_d   = key_q;
    case (cmd_i.op)
      wssc_pkg::OP_HIT: begin
        if (me) begin
          if (hit_sum > SUM_W'(wssc_pkg::WEIGHT_MAX)) begin
            wgt_d = wssc_pkg::WEIGHT_MAX;
          end else begin
            wgt_d = hit_sum[wssc_pkg::WGT_W-1:0];
          end
        end
      end
      wssc_pkg::OP_FILL: begin
        if (me) begin
          valid_d = 1'b1;
          key_d   = key_i;
          wgt_d   = $signed(fill_wgt);
        end
      end
      wssc_pkg::OP_DECAY: begin
        if (valid_q && (wgt_q != wssc_pkg::WEIGHT_MIN)) begin
          wgt_d = wgt_q - 16'sd1;
        end
      end
      wssc_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wgt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      wgt_q   <= wgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    scan_q <= scan_d;
  end

  assign scan_o = scan_q;

endmodule

### rtl/core/weighted_sample_slot_cache_top.sv
// ----------------------------------------------------------------------------
// weighted_sample_slot_cache_top: LFU slot cache with weight aging
// Sixteen slots in a chain of cells; a search packet walks the chain and
// the chosen update is broadcast back to the slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request (action, sound_key, priority_req); rsp_o
//   returns exactly one response per request, in order.
//   Reserve: the request key is held while a search packet walks the chain,
//   one cell per cycle; then the update is applied and the response is
//   loaded into the output register. Tick, clear and no-op requests skip
//   the walk and go straight to the apply stage. A new request is taken
//   only once the previous one has left the apply stage: req_i.ready is
//   high while no request is in progress.
//   The response sits in an output register: a new request is taken while
//   the previous response waits; if the receiver stalls, the next response
//   is held in the apply stage until the output register frees up.
//   decay_period is written over APB (register 0, byte address 0); the user
//   must change it only while the block is idle; the block has no check.
//   Reset: all slots invalid with weight zero, tick count zero, decay
//   period 60. Slot keys have no reset; they are read only behind valid.
// ----------------------------------------------------------------------------
module weighted_sample_slot_cache_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wssc_req_if.sink                      req_i,
  wssc_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wssc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e                               state_q, state_d;
  logic [wssc_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [wssc_pkg::TICK_W-1:0]          tick_q, tick_d;
  wssc_pkg::cmd_t                       cmd_q, cmd_d;
  logic                                 out_valid_q, out_valid_d;
  wssc_pkg::res_t                       pend_q, pend_d;
  wssc_pkg::res_t                       out_q, out_d;
  logic [wssc_pkg::KEY_W-1:0]           key_q, key_d;
  logic [wssc_pkg::PRIO_W-1:0]          prio_q, prio_d;
  logic [wssc_pkg::TICK_W-1:0]          decay_period;
  logic [wssc_pkg::TICK_W:0]            tick_next;
  wssc_pkg::scan_t                      chain [wssc_pkg::SLOTS+1];
  wssc_pkg::scan_t                      found;
  logic                                 accept;

  wssc_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .decay_period_o (decay_period)
  );

  // Chain of slot cells; a fresh packet enters cell 0 every cycle, and each
  // cell registers the packet before handing it to the next one.
  assign chain[0] = wssc_pkg::SCAN_INIT;

  for (genvar g = 0; g < wssc_pkg::SLOTS; g++) begin : g_cell
    wssc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (wssc_pkg::SLOT_W'(g)),
      .key_i      (key_q),
      .prio_i     (prio_q),
      .cmd_i      (cmd_q),
      .scan_i     (chain[g]),
      .scan_o     (chain[g+1])
    );
  end

  assign found     = chain[wssc_pkg::SLOTS];
  assign accept    = req_i.valid && req_i.ready;
  assign tick_next = {1'b0, tick_q} + 9'd1;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    cmd_d       = cmd_q;
    cmd_d.op    = wssc_pkg::OP_NONE;   // updates last one cycle
    pend_d      = pend_q;
    out_d       = out_q;
    key_d       = key_q;
    prio_d      = prio_q;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d  = req_i.sound_key;
          prio_d = req_i.priority_req;
          pend_d = '0;
          case (wssc_pkg::action_e'(req_i.action))
            wssc_pkg::ACT_RESERVE: begin
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            wssc_pkg::ACT_TICK: begin
              if (tick_next >= {1'b0, decay_period}) begin
                tick_d   = '0;
                cmd_d.op = wssc_pkg::OP_DECAY;
              end else begin
                tick_d = tick_next[wssc_pkg::TICK_W-1:0];
              end
              state_d = ST_APPLY;
            end
            wssc_pkg::ACT_CLEAR: begin
              cmd_d.op = wssc_pkg::OP_CLEAR;
              state_d  = ST_APPLY;
            end
            default: begin
              state_d = ST_APPLY;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == wssc_pkg::CNT_W'(wssc_pkg::SLOTS)) begin
          state_d = ST_APPLY;
          if (found.hit) begin
            cmd_d.op          = wssc_pkg::OP_HIT;
            cmd_d.idx         = found.hit_idx;
            pend_d.slot_index = wssc_pkg::IDX_W'(found.hit_idx);
            pend_d.hit        = 1'b1;
          end else if (found.free) begin
            cmd_d.op          = wssc_pkg::OP_FILL;
            cmd_d.idx         = found.free_idx;
            pend_d.slot_index = wssc_pkg::IDX_W'(found.free_idx);
          end else if (found.best) begin
            cmd_d.op          = wssc_pkg::OP_FILL;
            cmd_d.idx         = found.best_idx;
            pend_d.slot_index = wssc_pkg::IDX_W'(found.best_idx);
            pend_d.evicted    = 1'b1;
          end else begin
            pend_d.fault = 1'b1;
          end
        end
      end
      ST_APPLY: begin
        // cells take the update on entry; wait here for the output register
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tick_q      <= '0;
      cmd_q       <= '{op: wssc_pkg::OP_NONE, idx: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tick_q      <= tick_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    key_q  <= key_d;
    prio_q <= prio_d;
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.hit        = out_q.hit;
  assign rsp_o.evicted    = out_q.evicted;
  assign rsp_o.fault      = out_q.fault;

endmodule

### test/weighted_sample_slot_cache_top_tb.sv
// ----------------------------------------------------------------------------
// weighted_sample_slot_cache_top_tb: self-checking regression of the slot cache
// Sends reserve, tick, clear and no-op requests, predicts each response with
// a behavioral copy of the cache, and checks every response in order.
// ----------------------------------------------------------------------------
module weighted_sample_slot_cache_top_tb;
  import wssc_pkg::*;

  localparam int POOL_N = 20;         // keys shared by random reserves
  localparam int SETTLE = SLOTS + 8;  // cycles beyond the reserve latency

  // One row of the directed table; typed rows carry their own response.
  typedef struct packed {
    action_e           act;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    logic              typed;
    res_t              want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  wssc_req_if req_bus ();
  wssc_rsp_if rsp_bus ();

  weighted_sample_slot_cache_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted cache contents, updated at each accepted request.
  logic [KEY_W-1:0]        pred_key   [SLOTS];
  logic                    pred_valid [SLOTS];
  logic signed [WGT_W-1:0] pred_wgt   [SLOTS];
  logic [TICK_W-1:0]       pred_tick;
  logic [TICK_W-1:0]       pred_decay;

  res_t             rsp_want_q [$];   // responses still owed by the block
  row_t             plan_q     [$];   // directed table
  logic [KEY_W-1:0] key_pool   [POOL_N];

  // Typed response of the row on the bus, read when the request is taken.
  logic row_typed = 1'b0;
  res_t row_want  = '0;

  bit req_idle_on    = 1'b0;
  bit rsp_idle_on    = 1'b0;
  bit quiet_run      = 1'b0;  // stretch with no idling on either side
  int rsp_hold_len   = 0;     // long receiver hold-off, asked by the sequencer
  int rsp_stall_left = 0;

  int n_fail  = 0;
  int n_req   = 0;
  int n_hit   = 0;
  int n_fill  = 0;
  int n_evict = 0;
  int n_fault = 0;
  int n_decay = 0;

  res_t pred_res;
  res_t want_res;

  // --------------------------------------------------------------------------
  // Clock: period 10.
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("weighted_sample_slot_cache_top regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic signed [WGT_W-1:0] sat_wgt(input int w);
    if (w > int'(WEIGHT_MAX)) return WEIGHT_MAX;
    if (w < int'(WEIGHT_MIN)) return WEIGHT_MIN;
    return w[WGT_W-1:0];
  endfunction

  function automatic res_t rsp_of(input logic [IDX_W-1:0] idx, input logic h,
                                  input logic e, input logic f);
    res_t r;
    r.slot_index = idx;
    r.hit        = h;
    r.evicted    = e;
    r.fault      = f;
    return r;
  endfunction

  // Applies one request to the predicted cache and returns its response.
  function automatic res_t cache_predict(input action_e act, input logic [KEY_W-1:0] key,
                                         input logic [PRIO_W-1:0] prio);
    res_t r;
    int   pick;
    int   lowest;
    bit   done;
    r      = '0;
    done   = 1'b0;
    pick   = -1;
    lowest = int'(WEIGHT_CEIL);
    case (act)
      ACT_RESERVE: begin
        // hit: first valid slot holding the key gains prio + 1
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && pred_valid[i] && pred_key[i] == key) begin
            pred_wgt[i] = sat_wgt(int'(pred_wgt[i]) + int'(prio) + 1);
            r    = rsp_of(i[IDX_W-1:0], 1'b1, 1'b0, 1'b0);
            done = 1'b1;
          end
        end
        // miss: first free slot
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !pred_valid[i]) begin
            pred_valid[i] = 1'b1;
            pred_key[i]   = key;
            pred_wgt[i]   = sat_wgt(int'(prio) * MISS_GAIN);
            r    = rsp_of(i[IDX_W-1:0], 1'b0, 1'b0, 1'b0);
            done = 1'b1;
          end
        end
        // full: lowest weight under the ceiling, lower index on ties
        if (!done) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (pred_valid[i] && int'(pred_wgt[i]) < lowest) begin
              lowest = int'(pred_wgt[i]);
              pick   = i;
            end
          end
          if (pick < 0) begin
            r = rsp_of('0, 1'b0, 1'b0, 1'b1);
          end else begin
            pred_key[pick] = key;
            pred_wgt[pick] = sat_wgt(int'(prio) * MISS_GAIN);
            r = rsp_of(pick[IDX_W-1:0], 1'b0, 1'b1, 1'b0);
          end
        end
      end
      ACT_TICK: begin
        // period of zero behaves as one
        if (int'(pred_tick) + 1 >= int'(pred_decay)) begin
          pred_tick = '0;
          n_decay++;
          for (int i = 0; i < SLOTS; i++) begin
            if (pred_valid[i]) pred_wgt[i] = sat_wgt(int'(pred_wgt[i]) - 1);
          end
        end else begin
          pred_tick = pred_tick + 1'b1;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) pred_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predicts at request accept, checks at response accept.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (rsp_want_q.size() == 0) begin
          $error("response with no request outstanding");
          n_fail++;
        end else begin
          want_res = rsp_want_q.pop_front();
          if (rsp_bus.slot_index !== want_res.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want_res.slot_index, rsp_bus.slot_index);
            n_fail++;
          end
          if (rsp_bus.hit !== want_res.hit) begin
            $error("hit: expected %0d, got %0d", want_res.hit, rsp_bus.hit);
            n_fail++;
          end
          if (rsp_bus.evicted !== want_res.evicted) begin
            $error("evicted: expected %0d, got %0d", want_res.evicted, rsp_bus.evicted);
            n_fail++;
          end
          if (rsp_bus.fault !== want_res.fault) begin
            $error("fault: expected %0d, got %0d", want_res.fault, rsp_bus.fault);
            n_fail++;
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        pred_res = cache_predict(action_e'(req_bus.action), req_bus.sound_key,
                                 req_bus.priority_req);
        rsp_want_q.push_back(row_typed ? row_want : pred_res);
        n_req++;
        if (action_e'(req_bus.action) == ACT_RESERVE) begin
          if (pred_res.hit) n_hit++;
          else if (pred_res.evicted) n_evict++;
          else if (pred_res.fault) n_fault++;
          else n_fill++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_stall_left > 0) begin
        rsp_stall_left--;
        rsp_bus.ready = 1'b0;
      end else if (rsp_hold_len > 0) begin
        rsp_stall_left = rsp_hold_len - 1;
        rsp_hold_len   = 0;
        rsp_bus.ready  = 1'b0;
      end else if (rsp_idle_on && !quiet_run && $urandom_range(0, 5) == 0) begin
        rsp_stall_left = $urandom_range(0, 12);
        rsp_bus.ready  = 1'b0;
      end else begin
        rsp_bus.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register tasks; all start and end at a falling edge.
  // --------------------------------------------------------------------------
  task automatic drive_req(input action_e act, input logic [KEY_W-1:0] key,
                           input logic [PRIO_W-1:0] prio, input logic typed, input res_t want);
    if (req_idle_on && !quiet_run && $urandom_range(0, 4) == 0) begin
      req_bus.valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    req_bus.valid        = 1'b1;
    req_bus.action       = act;
    req_bus.sound_key    = key;
    req_bus.priority_req = prio;
    row_typed            = typed;
    row_want             = want;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_decay_reg(input logic [TICK_W-1:0] v);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b0;
    paddr   = ADDR_DECAY;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[TICK_W-1:0] !== v) begin
      $error("decay_period readback: expected %0d, got %0d", v, prdata[TICK_W-1:0]);
      n_fail++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Drains the block, then writes and reads back the decay period.
  task automatic set_decay(input logic [TICK_W-1:0] v);
    req_bus.valid = 1'b0;
    while (rsp_want_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    paddr   = ADDR_DECAY;
    pwdata  = {{(32-TICK_W){1'b0}}, v};
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pred_decay = v;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_decay_reg(v);
  endtask

  // Mostly reserves over a small key pool so that hits and evictions occur.
  task automatic send_random(input int n);
    action_e           act;
    logic [KEY_W-1:0]  key;
    logic [PRIO_W-1:0] prio;
    int                r;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) quiet_run = ($urandom_range(0, 3) == 0);
      r    = $urandom_range(0, 99);
      key  = KEY_W'($urandom);
      prio = PRIO_W'($urandom);
      if (r < 70) begin
        act = ACT_RESERVE;
        if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, POOL_N - 1)];
        case ($urandom_range(0, 7))
          0:       prio = '0;
          1:       prio = '1;
          default: ;
        endcase
      end else if (r < 94) begin
        act = ACT_TICK;
      end else if (r < 95) begin
        act = ACT_CLEAR;
      end else begin
        act = ACT_NOP;
      end
      drive_req(act, key, prio, 1'b0, '0);
    end
    quiet_run = 1'b0;
  endtask

  function automatic void add_row(input action_e act, input logic [KEY_W-1:0] key,
                                  input logic [PRIO_W-1:0] prio, input logic typed,
                                  input res_t want);
    row_t r;
    r.act   = act;
    r.key   = key;
    r.prio  = prio;
    r.typed = typed;
    r.want  = want;
    plan_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_bus.valid        = 1'b0;
    req_bus.action       = ACT_NOP;
    req_bus.sound_key    = '0;
    req_bus.priority_req = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pred_key[i]   = '0;
      pred_valid[i] = 1'b0;
      pred_wgt[i]   = '0;
    end
    pred_tick  = '0;
    pred_decay = DECAY_RESET;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = KEY_W'($urandom);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni      = 1'b1;
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;

    check_decay_reg(DECAY_RESET);

    // Directed table: key and priority extremes, every action, a hit on both
    // extreme keys, clear then refill from slot zero, and a full cache whose
    // two zero-weight slots tie (the lower index is replaced).
    add_row(ACT_RESERVE, 16'h0000, 8'd0,   1'b1, rsp_of(4'd0, 1'b0, 1'b0, 1'b0));
    add_row(ACT_RESERVE, 16'hFFFF, 8'd255, 1'b1, rsp_of(4'd1, 1'b0, 1'b0, 1'b0));
    add_row(ACT_RESERVE, 16'hFFFF, 8'd255, 1'b1, rsp_of(4'd1, 1'b1, 1'b0, 1'b0));
    add_row(ACT_RESERVE, 16'h0000, 8'd0,   1'b1, rsp_of(4'd0, 1'b1, 1'b0, 1'b0));
    add_row(ACT_TICK,    16'hFFFF, 8'd255, 1'b1, '0);
    add_row(ACT_NOP,     16'hFFFF, 8'd255, 1'b1, '0);
    add_row(ACT_RESERVE, 16'h1234, 8'd1,   1'b0, '0);
    add_row(ACT_CLEAR,   16'h0000, 8'd0,   1'b1, '0);
    add_row(ACT_RESERVE, 16'hFFFF, 8'd128, 1'b1, rsp_of(4'd0, 1'b0, 1'b0, 1'b0));
    add_row(ACT_RESERVE, 16'hAAAA, 8'h55,  1'b0, '0);
    add_row(ACT_RESERVE, 16'h5555, 8'hAA,  1'b0, '0);
    for (int i = 3; i < SLOTS; i++) begin
      add_row(ACT_RESERVE, KEY_W'(16'h0100 + i),
              (i == 5 || i == 9) ? 8'd0 : PRIO_W'(i * 17), 1'b0, '0);
    end
    add_row(ACT_RESERVE, 16'hBEEF, 8'd7, 1'b1, rsp_of(4'd5, 1'b0, 1'b1, 1'b0));
    foreach (plan_q[i]) begin
      drive_req(plan_q[i].act, plan_q[i].key, plan_q[i].prio, plan_q[i].typed, plan_q[i].want);
    end

    // Random phases over several decay periods, extremes included.
    set_decay(8'd255);
    send_random(200);
    set_decay(8'd1);
    rsp_hold_len = 400;    // receiver backs off; block fills and stalls input
    send_random(200);
    set_decay(8'd0);
    send_random(100);
    set_decay(TICK_W'($urandom_range(2, 254)));
    send_random(130);

    // Upper saturation, no idling: every slot filled, slot zero pumped past
    // the weight maximum by repeated hits; a miss must then replace the
    // next lowest slot and leave slot zero alone.
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    set_decay(8'd255);
    drive_req(ACT_CLEAR, '0, '0, 1'b1, '0);
    for (int i = 0; i < SLOTS; i++) begin
      drive_req(ACT_RESERVE, KEY_W'(16'hC000 + i), 8'd200, 1'b0, '0);
    end
    repeat (126) drive_req(ACT_RESERVE, 16'hC000, 8'd255, 1'b0, '0);
    drive_req(ACT_RESERVE, 16'hC000, 8'd255, 1'b1, rsp_of(4'd0, 1'b1, 1'b0, 1'b0));
    drive_req(ACT_RESERVE, 16'hD000, 8'd9,   1'b1, rsp_of(4'd1, 1'b0, 1'b1, 1'b0));

    // Drain and settle.
    req_bus.valid = 1'b0;
    while (rsp_want_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("Ran %0d requests: %0d hits, %0d fills, %0d evictions, %0d faults, %0d decays.",
             n_req, n_hit, n_fill, n_evict, n_fault, n_decay);
    $display("Decay periods 60, 255, 1, 0 and one random; one slot held at the weight maximum.");
    if (n_fail == 0) begin
      $display("weighted_sample_slot_cache_top regression: pass");
    end else begin
      $display("weighted_sample_slot_cache_top regression: fail");
    end
    $finish;
  end

endmodule
